@@ hw/rtl/rsm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsm_pkg
// Shared types, widths and the polyphase kernel table of the stereo resampler.
// ----------------------------------------------------------------------------
package rsm_pkg;

	localparam int TAPS       = 8;
	localparam int PHASES     = 32;
	localparam int MAX_RUN    = 8;
	localparam int TAP_W      = 3;
	localparam int ROW_W      = 5;
	localparam int RUN_W      = 3;
	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int PROD_W     = 32;
	localparam int ACC_W      = 34;
	localparam int STEP_W     = 34;
	localparam int PHASE_W    = 35;
	localparam int FRAC_W     = 32;
	localparam int INT_W      = PHASE_W - FRAC_W;
	localparam int FILL_W     = 4;
	localparam int COEF_SHIFT = 14;

	localparam logic [FILL_W-1:0] FILL_RESET = 4'd3;
	localparam logic [STEP_W-1:0] STEP_RESET = 34'h1_0000_0000;
	localparam logic signed [ACC_W:0] ROUND_HALF = 35'sh2000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	// One queued input word: the stereo pair and whether it starts a run.
	typedef struct packed {
		sample_t left;
		sample_t right;
		logic    run;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MAC,
		BK_DRAIN,
		BK_EMIT
	} bk_state_t;

	// Kernel rows, 2.14 fixed point, tap 0 applies to the oldest sample.
	localparam coef_t COEF_ROWS [PHASES][TAPS] = '{
		'{ 16'sh0000,  16'sh0000,  16'sh0000,  16'sh4000,
		   16'sh0000,  16'sh0000,  16'sh0000,  16'sh0000},
		'{-16'sh000a,  16'sh0052, -16'sh0179,  16'sh3fe2,
		   16'sh019f, -16'sh005b,  16'sh000c,  16'sh0000},
		'{-16'sh0013,  16'sh009c, -16'sh02cc,  16'sh3f86,
		   16'sh0362, -16'sh00c0,  16'sh001a,  16'sh0000},
		'{-16'sh001a,  16'sh00dc, -16'sh03f9,  16'sh3eef,
		   16'sh054a, -16'sh012c,  16'sh002b,  16'sh0000},
		'{-16'sh001f,  16'sh0113, -16'sh0500,  16'sh3e1d,
		   16'sh0753, -16'sh01a0,  16'sh003d,  16'sh0000},
		'{-16'sh0023,  16'sh0141, -16'sh05e1,  16'sh3d12,
		   16'sh097c, -16'sh021a,  16'sh0050, -16'sh0001},
		'{-16'sh0026,  16'sh0166, -16'sh069e,  16'sh3bd0,
		   16'sh0bc4, -16'sh029a,  16'sh0066, -16'sh0001},
		'{-16'sh0027,  16'sh0182, -16'sh0738,  16'sh3a5a,
		   16'sh0e27, -16'sh031f,  16'sh007d, -16'sh0002},
		'{-16'sh0028,  16'sh0197, -16'sh07b0,  16'sh38b2,
		   16'sh10a2, -16'sh03a7,  16'sh0096, -16'sh0003},
		'{-16'sh0027,  16'sh01a5, -16'sh0807,  16'sh36dc,
		   16'sh1333, -16'sh0430,  16'sh00af, -16'sh0005},
		'{-16'sh0026,  16'sh01ab, -16'sh083f,  16'sh34db,
		   16'sh15d5, -16'sh04ba,  16'sh00ca, -16'sh0007},
		'{-16'sh0024,  16'sh01ac, -16'sh085b,  16'sh32b3,
		   16'sh1886, -16'sh0541,  16'sh00e5, -16'sh0008},
		'{-16'sh0022,  16'sh01a6, -16'sh085d,  16'sh3068,
		   16'sh1b40, -16'sh05c6,  16'sh0101, -16'sh000b},
		'{-16'sh001f,  16'sh019c, -16'sh0846,  16'sh2dfe,
		   16'sh1e00, -16'sh0644,  16'sh011c, -16'sh000d},
		'{-16'sh001c,  16'sh018e, -16'sh0819,  16'sh2b7a,
		   16'sh20c1, -16'sh06bb,  16'sh0136, -16'sh0010},
		'{-16'sh0019,  16'sh017c, -16'sh07d9,  16'sh28e1,
		   16'sh2380, -16'sh0727,  16'sh014f, -16'sh0013},
		'{-16'sh0016,  16'sh0167, -16'sh0788,  16'sh2637,
		   16'sh2637, -16'sh0788,  16'sh0167, -16'sh0016},
		'{-16'sh0013,  16'sh014f, -16'sh0727,  16'sh2380,
		   16'sh28e1, -16'sh07d9,  16'sh017c, -16'sh0019},
		'{-16'sh0010,  16'sh0136, -16'sh06bb,  16'sh20c1,
		   16'sh2b7a, -16'sh0819,  16'sh018e, -16'sh001c},
		'{-16'sh000d,  16'sh011c, -16'sh0644,  16'sh1e00,
		   16'sh2dfe, -16'sh0846,  16'sh019c, -16'sh001f},
		'{-16'sh000b,  16'sh0101, -16'sh05c6,  16'sh1b40,
		   16'sh3068, -16'sh085d,  16'sh01a6, -16'sh0022},
		'{-16'sh0008,  16'sh00e5, -16'sh0541,  16'sh1886,
		   16'sh32b3, -16'sh085b,  16'sh01ac, -16'sh0024},
		'{-16'sh0007,  16'sh00ca, -16'sh04ba,  16'sh15d5,
		   16'sh34db, -16'sh083f,  16'sh01ab, -16'sh0026},
		'{-16'sh0005,  16'sh00af, -16'sh0430,  16'sh1333,
		   16'sh36dc, -16'sh0807,  16'sh01a5, -16'sh0027},
		'{-16'sh0003,  16'sh0096, -16'sh03a7,  16'sh10a2,
		   16'sh38b2, -16'sh07b0,  16'sh0197, -16'sh0028},
		'{-16'sh0002,  16'sh007d, -16'sh031f,  16'sh0e27,
		   16'sh3a5a, -16'sh0738,  16'sh0182, -16'sh0027},
		'{-16'sh0001,  16'sh0066, -16'sh029a,  16'sh0bc4,
		   16'sh3bd0, -16'sh069e,  16'sh0166, -16'sh0026},
		'{-16'sh0001,  16'sh0050, -16'sh021a,  16'sh097c,
		   16'sh3d12, -16'sh05e1,  16'sh0141, -16'sh0023},
		'{ 16'sh0000,  16'sh003d, -16'sh01a0,  16'sh0753,
		   16'sh3e1d, -16'sh0500,  16'sh0113, -16'sh001f},
		'{ 16'sh0000,  16'sh002b, -16'sh012c,  16'sh054a,
		   16'sh3eef, -16'sh03f9,  16'sh00dc, -16'sh001a},
		'{ 16'sh0000,  16'sh001a, -16'sh00c0,  16'sh0362,
		   16'sh3f86, -16'sh02cc,  16'sh009c, -16'sh0013},
		'{ 16'sh0000,  16'sh000c, -16'sh005b,  16'sh019f,
		   16'sh3fe2, -16'sh0179,  16'sh0052, -16'sh000a}
	};

endpackage
`default_nettype wire

@@ hw/rtl/rsm_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsm_in_if
// Input stream channel: one stereo sample pair per word.
// ----------------------------------------------------------------------------
interface rsm_in_if;
	logic                valid;
	logic                ready;
	rsm_pkg::sample_t    left_in;
	rsm_pkg::sample_t    right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink   (input valid, input left_in, input right_in, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rsm_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsm_out_if
// Result stream channel: one filtered stereo pair per word plus run marker.
// ----------------------------------------------------------------------------
interface rsm_out_if;
	logic                valid;
	logic                ready;
	rsm_pkg::sample_t    left_out;
	rsm_pkg::sample_t    right_out;
	logic                last_of_run;

	modport source (output valid, output left_out, output right_out,
		output last_of_run, input ready);
	modport sink   (input valid, input left_out, input right_out,
		input last_of_run, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rsm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsm_front
// Accepts input words, tracks history fill and tags words that start a run.
// ----------------------------------------------------------------------------
module rsm_front (
	input  logic            clk,
	input  logic            arst_n,
	rsm_in_if.sink          samples,
	output rsm_pkg::push_t  push,
	input  logic            push_ready
);
	import rsm_pkg::*;

	logic [FILL_W-1:0] fill_q;
	logic              full;
	logic              accept;

	assign full   = (fill_q == FILL_W'(TAPS));
	assign accept = samples.valid && push_ready;

	assign samples.ready     = push_ready;
	assign push.valid        = samples.valid;
	assign push.entry.left   = samples.left_in;
	assign push.entry.right  = samples.right_in;
	// the word that completes the window already runs the filter
	assign push.entry.run    = full || (fill_q == FILL_W'(TAPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= FILL_RESET;
		end else if (accept && !full) begin
			fill_q <= fill_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/rsm_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsm_queue
// Small FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module rsm_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rsm_pkg::push_t  push,
	output logic            push_ready,
	output rsm_pkg::push_t  pop,
	input  logic            pop_ready
);
	import rsm_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop.valid  = (count_q != '0);
	assign pop.entry  = slot_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop.valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/rsm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsm_back
// History, phase accumulator, tap-serial multiply-add and result register.
// ----------------------------------------------------------------------------
module rsm_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step_we,
	input  logic [rsm_pkg::STEP_W-1:0]  step_wdata,
	input  rsm_pkg::push_t              pop,
	output logic                        pop_ready,
	rsm_out_if.source                   results
);
	import rsm_pkg::*;

	function automatic sample_t round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W:0]              rnd;
		logic signed [ACC_W-COEF_SHIFT:0]   shq;
		sample_t                            res;
		rnd = {acc[ACC_W-1], acc} + ROUND_HALF;
		shq = rnd[ACC_W:COEF_SHIFT];
		if (!shq[ACC_W-COEF_SHIFT] && (|shq[ACC_W-COEF_SHIFT-1:SAMPLE_W-1])) begin
			res = 16'sh7fff;
		end else if (shq[ACC_W-COEF_SHIFT] && !(&shq[ACC_W-COEF_SHIFT-1:SAMPLE_W-1])) begin
			res = -16'sh8000;
		end else begin
			res = shq[SAMPLE_W-1:0];
		end
		return res;
	endfunction

	bk_state_t                  state_q;
	bk_state_t                  state_d;
	sample_t                    hist_l_q [TAPS];
	sample_t                    hist_r_q [TAPS];
	logic [PHASE_W-1:0]         phase_q;
	logic [STEP_W-1:0]          step_q;
	logic [TAP_W-1:0]           tap_q;
	logic [RUN_W-1:0]           run_q;
	logic signed [PROD_W-1:0]   prod_l_s1;
	logic signed [PROD_W-1:0]   prod_r_s1;
	logic                       prod_vld_s1;
	logic signed [ACC_W-1:0]    acc_l_q;
	logic signed [ACC_W-1:0]    acc_r_q;
	logic                       out_vld_q;
	sample_t                    out_l_q;
	sample_t                    out_r_q;
	logic                       out_last_q;

	logic                       int_zero;
	logic [ROW_W-1:0]           row;
	coef_t                      coef;
	logic [PHASE_W-1:0]         next_phase;
	logic                       next_int_nz;
	logic                       run_end;
	logic                       out_free;
	logic                       take;
	logic                       start_mac;
	logic                       skip_unit;
	logic                       emit;
	logic                       mac_issue;

	assign int_zero    = (phase_q[PHASE_W-1:FRAC_W] == '0);
	assign row         = phase_q[FRAC_W-1 -: ROW_W];
	assign coef        = COEF_ROWS[row][tap_q];
	assign next_phase  = phase_q + PHASE_W'(step_q);
	assign next_int_nz = |next_phase[PHASE_W-1:FRAC_W];
	assign run_end     = (run_q == RUN_W'(MAX_RUN - 1)) || next_int_nz;
	assign out_free    = !out_vld_q || results.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (pop.valid && pop.entry.run && int_zero) begin
					state_d = BK_MAC;
				end
			end
			BK_MAC: begin
				if (tap_q == TAP_W'(TAPS - 1)) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (out_free) begin
					state_d = run_end ? BK_IDLE : BK_MAC;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		pop_ready = 1'b0;
		take      = 1'b0;
		start_mac = 1'b0;
		skip_unit = 1'b0;
		emit      = 1'b0;
		mac_issue = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				take      = pop.valid;
				start_mac = pop.valid && pop.entry.run && int_zero;
				skip_unit = pop.valid && pop.entry.run && !int_zero;
			end
			BK_MAC: begin
				mac_issue = 1'b1;
			end
			BK_DRAIN: begin
			end
			BK_EMIT: begin
				emit      = out_free;
				start_mac = out_free && !run_end;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			step_q      <= STEP_RESET;
			phase_q     <= '0;
			tap_q       <= '0;
			run_q       <= '0;
			prod_vld_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
			for (int i = 0; i < TAPS; i++) begin
				hist_l_q[i] <= '0;
				hist_r_q[i] <= '0;
			end
		end else begin
			state_q     <= state_d;
			prod_vld_s1 <= mac_issue;
			if (step_we) begin
				step_q <= step_wdata;
			end
			// shift the new pair in, oldest at tap 0
			if (take) begin
				for (int i = 0; i < TAPS - 1; i++) begin
					hist_l_q[i] <= hist_l_q[i + 1];
					hist_r_q[i] <= hist_r_q[i + 1];
				end
				hist_l_q[TAPS - 1] <= pop.entry.left;
				hist_r_q[TAPS - 1] <= pop.entry.right;
			end
			if (skip_unit) begin
				phase_q <= {phase_q[PHASE_W-1:FRAC_W] - 1'b1, phase_q[FRAC_W-1:0]};
			end else if (emit) begin
				if (next_int_nz) begin
					phase_q <= {next_phase[PHASE_W-1:FRAC_W] - 1'b1,
						next_phase[FRAC_W-1:0]};
				end else begin
					phase_q <= next_phase;
				end
			end
			if (start_mac) begin
				tap_q <= '0;
			end else if (mac_issue) begin
				tap_q <= tap_q + 1'b1;
			end
			if (take) begin
				run_q <= '0;
			end else if (emit) begin
				run_q <= run_q + 1'b1;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (mac_issue) begin
			prod_l_s1 <= PROD_W'(hist_l_q[tap_q]) * PROD_W'(coef);
			prod_r_s1 <= PROD_W'(hist_r_q[tap_q]) * PROD_W'(coef);
		end
		if (start_mac) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else if (prod_vld_s1) begin
			acc_l_q <= acc_l_q + ACC_W'(prod_l_s1);
			acc_r_q <= acc_r_q + ACC_W'(prod_r_s1);
		end
		if (emit) begin
			out_l_q    <= round_sat(acc_l_q);
			out_r_q    <= round_sat(acc_r_q);
			out_last_q <= run_end;
		end
	end

	assign results.valid       = out_vld_q;
	assign results.left_out    = out_l_q;
	assign results.right_out   = out_r_q;
	assign results.last_of_run = out_last_q;

endmodule
`default_nettype wire

@@ hw/rtl/polyphase_stereo_resampler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyphase_stereo_resampler
// Stereo 8-tap, 32-phase polyphase FIR sample-rate converter.
// ----------------------------------------------------------------------------
// Usage:
//   samples  - input stream, one stereo pair per word (valid/ready).
//   results  - output stream, one filtered pair per word; last_of_run marks
//              the final word caused by one input word.
//   step_we / step_wdata - write the 2.32 step increment; write only while
//              the block is idle. Reset value is one input sample per output.
// After reset the history holds three zero samples; the first four input
// words only fill the window and produce nothing.
// Timing: the front takes a word whenever the queue has room. The back pops
// a word, then for each output word steps through the 8 taps on one shared
// multiplier pair, one drain and one emit step; it pops no new word until
// its last output word, at most 8, is emitted. Words that yield nothing
// are taken in the idle state alone. With the back idle, the first output
// word passes the queue, the idle, tap, drain and emit states and the result
// register. A stalled receiver holds the back in its emit state; the queue
// keeps accepting input words until it is full, then ready drops.
// ----------------------------------------------------------------------------
module polyphase_stereo_resampler #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step_we,
	input  logic [rsm_pkg::STEP_W-1:0]  step_wdata,
	rsm_in_if.sink                      samples,
	rsm_out_if.source                   results
);
	import rsm_pkg::*;

	push_t  push;
	logic   push_ready;
	push_t  pop;
	logic   pop_ready;

	// classify: track fill, tag words that run the filter
	rsm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.push       (push),
		.push_ready (push_ready)
	);

	// decouple intake from the filter so each side can stall on its own
	rsm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_ready  (pop_ready)
	);

	// shift history, advance phase, filter and hold the result word
	rsm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_we    (step_we),
		.step_wdata (step_wdata),
		.pop        (pop),
		.pop_ready  (pop_ready),
		.results    (results)
	);

endmodule
`default_nettype wire
